// ===== hdl/bsas_pkg.sv =====
// Shared widths, codes and types of the byte stride allocation sampler.
package bsas_pkg;

  localparam int SIZE_W      = 48;
  localparam int ADDR_W      = 48;
  localparam int STRIDE_W    = 32;
  localparam int COUNT_W     = 64;
  localparam int ADDED_W     = 39;
  localparam int SLOT_OUT_W  = 6;
  localparam int RING_DEPTH  = 64;
  localparam int RING_SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RING_W      = SIZE_W + ADDR_W + COUNT_W;
  localparam int DIV_CNT_W   = $clog2(SIZE_W + 1);

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 32'd262144;
  localparam logic [STRIDE_W-1:0] STRIDE_MIN   = 32'd1024;

  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STRIDE = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [SIZE_W-1:0]   dividend;
    logic [STRIDE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [SIZE_W-1:0]   quotient;
    logic [STRIDE_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== hdl/bsas_if.sv =====
// Valid/ready channel interfaces for allocation events and sampler results.
interface bsas_in_if;
  logic                       valid;
  logic                       ready;
  logic [bsas_pkg::SIZE_W-1:0] alloc_size;
  logic [bsas_pkg::ADDR_W-1:0] alloc_address;

  modport source (output valid, output alloc_size, output alloc_address, input ready);
  modport sink   (input valid, input alloc_size, input alloc_address, output ready);
endinterface

interface bsas_out_if;
  logic                            valid;
  logic                            ready;
  logic                            sampled;
  logic [bsas_pkg::ADDED_W-1:0]    samples_added;
  logic [bsas_pkg::SLOT_OUT_W-1:0] ring_slot;
  logic [bsas_pkg::COUNT_W-1:0]    alloc_total;
  logic [bsas_pkg::COUNT_W-1:0]    sample_total;
  logic [bsas_pkg::STRIDE_W-1:0]   bytes_to_next;

  modport source (output valid, output sampled, output samples_added, output ring_slot,
                  output alloc_total, output sample_total, output bytes_to_next,
                  input ready);
  modport sink   (input valid, input sampled, input samples_added, input ring_slot,
                  input alloc_total, input sample_total, input bytes_to_next,
                  output ready);
endinterface

// ===== hdl/byte_stride_alloc_sampler.sv =====
// Top level of the byte stride allocation sampler.
//
//   channel  direction  carries
//   req      in         alloc_size, alloc_address (valid/ready)
//   rsp      out        sampled, samples_added, ring_slot, alloc_total,
//                       sample_total, bytes_to_next (valid/ready)
//   cfg      in         cfg_we, cfg_index, cfg_data (write only)
//
// An item that crosses no threshold passes through the check and result states
// to the output register before the next item can be accepted; one that crosses
// a threshold also waits in the divide state for the bit-serial divider, which
// produces one of its 48 quotient bits per cycle.
// One item is in work at a time. rst is synchronous and clears the counters,
// the countdown and the enable; it returns the stride to its reset value. A
// stalled output holds its item and keeps the block from finishing the next one.
module byte_stride_alloc_sampler (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bsas_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bsas_pkg::CFG_DATA_W-1:0]    cfg_data,
  bsas_in_if.sink                            req,
  bsas_out_if.source                         rsp
);

  bsas_pkg::state_t state;
  bsas_pkg::state_t state_next;

  logic                              enable;
  logic [bsas_pkg::STRIDE_W-1:0]     stride_bytes;
  logic [bsas_pkg::STRIDE_W-1:0]     countdown;
  logic [bsas_pkg::COUNT_W-1:0]      alloc_counter;
  logic [bsas_pkg::COUNT_W-1:0]      sample_counter;
  logic [bsas_pkg::RING_SLOT_W-1:0]  slot;

  logic [bsas_pkg::SIZE_W-1:0]       size_q;
  logic [bsas_pkg::ADDR_W-1:0]       addr_q;
  logic                              hit_q;
  logic [bsas_pkg::ADDED_W-1:0]      added_q;
  logic [bsas_pkg::RING_SLOT_W-1:0]  slot_q;

  logic                              out_valid;
  logic                              out_sampled;
  logic [bsas_pkg::ADDED_W-1:0]      out_added;
  logic [bsas_pkg::SLOT_OUT_W-1:0]   out_slot;
  logic [bsas_pkg::COUNT_W-1:0]      out_alloc_total;
  logic [bsas_pkg::COUNT_W-1:0]      out_sample_total;
  logic [bsas_pkg::STRIDE_W-1:0]     out_bytes_to_next;

  logic [bsas_pkg::STRIDE_W-1:0]     cd_eff;
  logic                              below;
  logic [bsas_pkg::SIZE_W-1:0]       over;
  logic                              sample_hit;
  logic                              out_free;
  logic [bsas_pkg::ADDED_W-1:0]      added_w;
  logic [bsas_pkg::COUNT_W-1:0]      alloc_inc;

  bsas_pkg::div_req_t div_req;
  bsas_pkg::div_rsp_t div_rsp;

  // A zero countdown means the stride has not been loaded yet.
  assign cd_eff     = (countdown == '0) ? stride_bytes : countdown;
  assign below      = size_q < bsas_pkg::SIZE_W'(cd_eff);
  assign over       = size_q - bsas_pkg::SIZE_W'(cd_eff);
  assign sample_hit = (state == bsas_pkg::ST_CHECK) && enable && !below;
  assign out_free   = !out_valid || rsp.ready;
  assign added_w    = div_rsp.quotient[bsas_pkg::ADDED_W-1:0] + bsas_pkg::ADDED_W'(1);
  assign alloc_inc  = alloc_counter + bsas_pkg::COUNT_W'(1);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      stride_bytes <= bsas_pkg::STRIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsas_pkg::CFG_ENABLE: enable <= cfg_data[0];
        bsas_pkg::CFG_STRIDE: begin
          if (cfg_data >= bsas_pkg::STRIDE_MIN) begin
            stride_bytes <= cfg_data;
          end
        end
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bsas_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = bsas_pkg::ST_CHECK;
        end
      end
      bsas_pkg::ST_CHECK: begin
        state_next = sample_hit ? bsas_pkg::ST_DIVIDE : bsas_pkg::ST_RESULT;
      end
      bsas_pkg::ST_DIVIDE: begin
        if (div_rsp.done) begin
          state_next = bsas_pkg::ST_RESULT;
        end
      end
      bsas_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = bsas_pkg::ST_IDLE;
        end
      end
      default: state_next = bsas_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    req.ready        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = over;
    div_req.divisor  = stride_bytes;
    unique case (state)
      bsas_pkg::ST_IDLE:   req.ready = 1'b1;
      bsas_pkg::ST_CHECK:  div_req.start = sample_hit;
      bsas_pkg::ST_DIVIDE: ;
      bsas_pkg::ST_RESULT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsas_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sampler state
  always_ff @(posedge clk) begin
    if (rst) begin
      countdown      <= '0;
      alloc_counter  <= '0;
      sample_counter <= '0;
      slot           <= '0;
    end else begin
      if (state == bsas_pkg::ST_CHECK && enable) begin
        alloc_counter <= alloc_inc;
        if (below) begin
          countdown <= cd_eff - size_q[bsas_pkg::STRIDE_W-1:0];
        end else if (slot == bsas_pkg::RING_SLOT_W'(bsas_pkg::RING_DEPTH - 1)) begin
          slot <= '0;
        end else begin
          slot <= slot + 1'b1;
        end
      end
      if (state == bsas_pkg::ST_DIVIDE && div_rsp.done) begin
        sample_counter <= sample_counter + bsas_pkg::COUNT_W'(added_w);
        countdown      <= stride_bytes - div_rsp.remainder;
      end
    end
  end

  // Item payload and per-item result flags
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      size_q <= req.alloc_size;
      addr_q <= req.alloc_address;
    end
    if (state == bsas_pkg::ST_CHECK) begin
      hit_q   <= sample_hit;
      added_q <= '0;
      slot_q  <= sample_hit ? slot : '0;
    end
    if (state == bsas_pkg::ST_DIVIDE && div_rsp.done) begin
      added_q <= added_w;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == bsas_pkg::ST_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bsas_pkg::ST_RESULT && out_free) begin
      out_sampled       <= hit_q;
      out_added         <= added_q;
      out_slot          <= bsas_pkg::SLOT_OUT_W'(slot_q);
      out_alloc_total   <= alloc_counter;
      out_sample_total  <= sample_counter;
      out_bytes_to_next <= countdown;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.sampled       = out_sampled;
  assign rsp.samples_added = out_added;
  assign rsp.ring_slot     = out_slot;
  assign rsp.alloc_total   = out_alloc_total;
  assign rsp.sample_total  = out_sample_total;
  assign rsp.bytes_to_next = out_bytes_to_next;

  bsas_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sample records: size, address and allocation count, one slot per sampled item.
  bsas_ram #(
    .WIDTH (bsas_pkg::RING_W),
    .DEPTH (bsas_pkg::RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (sample_hit),
    .wr_addr (slot),
    .wr_data ({size_q, addr_q, alloc_inc}),
    .rd_addr (slot),
    .rd_data ()
  );

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == bsas_pkg::ST_CHECK)
    else $error("accepted item did not enter the check step");

  a_div_done_to_result: assert property (@(posedge clk) disable iff (rst)
    state == bsas_pkg::ST_DIVIDE && div_rsp.done |=> state == bsas_pkg::ST_RESULT)
    else $error("divider finished but no result was formed");

  a_hit_adds_samples: assert property (@(posedge clk) disable iff (rst)
    state == bsas_pkg::ST_RESULT && hit_q |-> added_q != '0)
    else $error("sampled item carries no samples");

  a_disabled_keeps_state: assert property (@(posedge clk) disable iff (rst)
    state == bsas_pkg::ST_CHECK && !enable |=> $stable(alloc_counter) && $stable(countdown))
    else $error("disabled item changed the sampler state");

endmodule

// ===== hdl/bsas_ram.sv =====
// Generic single-write RAM with one registered read port.
module bsas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/bsas_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module bsas_div (
  input  logic               clk,
  input  logic               rst,
  input  bsas_pkg::div_req_t req,
  output bsas_pkg::div_rsp_t rsp
);

  logic [bsas_pkg::STRIDE_W-1:0]  divisor;
  logic [bsas_pkg::STRIDE_W-1:0]  rem;
  logic [bsas_pkg::SIZE_W-1:0]    quo;
  logic [bsas_pkg::DIV_CNT_W-1:0] count;
  logic                           busy;
  logic                           done;

  logic [bsas_pkg::STRIDE_W:0] shifted;
  logic [bsas_pkg::STRIDE_W:0] diff;
  logic                        ge;

  // The dividend shifts out of the top of the quotient register as quotient
  // bits shift in at the bottom.
  assign shifted = {rem, quo[bsas_pkg::SIZE_W-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= bsas_pkg::DIV_CNT_W'(bsas_pkg::SIZE_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == bsas_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      rem     <= '0;
      quo     <= req.dividend;
    end else if (busy) begin
      rem <= ge ? diff[bsas_pkg::STRIDE_W-1:0] : shifted[bsas_pkg::STRIDE_W-1:0];
      quo <= {quo[bsas_pkg::SIZE_W-2:0], ge};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the byte stride allocation sampler.
`timescale 1ns / 1ps

module tb;
  import bsas_pkg::*;

  localparam int HOLD_CYCLES = 500;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } alloc_ev_t;

  typedef struct packed {
    logic                  sampled;
    logic [ADDED_W-1:0]    added;
    logic [SLOT_OUT_W-1:0] slot;
    logic [COUNT_W-1:0]    alloc_total;
    logic [COUNT_W-1:0]    sample_total;
    logic [STRIDE_W-1:0]   bytes_to_next;
  } sampler_rsp_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bsas_in_if  req_if ();
  bsas_out_if rsp_if ();

  byte_stride_alloc_sampler DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  // Predicted state of the sampler.
  logic                smp_enable;
  logic [STRIDE_W-1:0] smp_stride;
  logic [STRIDE_W-1:0] smp_countdown;
  logic [COUNT_W-1:0]  smp_allocs;
  logic [COUNT_W-1:0]  smp_samples;
  logic [COUNT_W-1:0]  smp_head;

  alloc_ev_t    pending_ev[$];
  sampler_rsp_t expected_rsp[$];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int rsp_seen;
  bit hold_arm;
  logic hold_rx;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic sampler_rsp_t sample_alloc(input logic [SIZE_W-1:0] size);
    sampler_rsp_t r;
    logic [63:0] over;
    logic [63:0] added;
    r = '0;
    if (smp_enable) begin
      if (smp_countdown == '0)
        smp_countdown = smp_stride;
      smp_allocs = smp_allocs + 1'b1;
      if (64'(size) < 64'(smp_countdown)) begin
        smp_countdown = smp_countdown - size[STRIDE_W-1:0];
      end else begin
        over  = 64'(size) - 64'(smp_countdown);
        added = over / 64'(smp_stride) + 64'd1;
        smp_samples = smp_samples + added;
        r.sampled = 1'b1;
        r.added   = added[ADDED_W-1:0];
        r.slot    = SLOT_OUT_W'(smp_head % RING_DEPTH);
        smp_head  = smp_head + 1'b1;
        smp_countdown = smp_stride - STRIDE_W'(over % 64'(smp_stride));
      end
    end
    r.alloc_total   = smp_allocs;
    r.sample_total  = smp_samples;
    r.bytes_to_next = smp_countdown;
    return r;
  endfunction

  // Countdown that the next enabled item will be measured against.
  function automatic logic [STRIDE_W-1:0] next_countdown();
    return (smp_countdown == '0) ? smp_stride : smp_countdown;
  endfunction

  function automatic logic [47:0] random48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  // Most sizes are drawn relative to the stride so that thresholds are crossed often.
  function automatic logic [SIZE_W-1:0] random_size(input logic [STRIDE_W-1:0] stride);
    logic [63:0] s;
    s = 64'(stride);
    case ($urandom_range(9))
      0: return SIZE_W'($urandom_range(1023));
      1: return SIZE_W'(s - 64'd1 + 64'($urandom_range(2)));
      2: return SIZE_W'(s * 64'($urandom_range(1, 4)) - 64'($urandom_range(1023)));
      3: return random48();
      4: return SIZE_W'(s * 64'($urandom_range(1, 1000)));
      5: return '1;
      default: return SIZE_W'($urandom_range(0, stride / 2));
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] random_addr();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return random48();
    endcase
  endfunction

  // Item driver.
  always @(posedge clk) begin : driver
    alloc_ev_t ev;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready)
        expected_rsp.push_back(sample_alloc(req_if.alloc_size));
      if (!req_if.valid || req_if.ready) begin
        if (pending_ev.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          ev = pending_ev.pop_front();
          req_if.valid         <= 1'b1;
          req_if.alloc_size    <= ev.size;
          req_if.alloc_address <= ev.addr;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker.
  always @(posedge clk) begin : monitor
    sampler_rsp_t got;
    sampler_rsp_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.sampled       = rsp_if.sampled;
        got.added         = rsp_if.samples_added;
        got.slot          = rsp_if.ring_slot;
        got.alloc_total   = rsp_if.alloc_total;
        got.sample_total  = rsp_if.sample_total;
        got.bytes_to_next = rsp_if.bytes_to_next;
        if (expected_rsp.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d arrived with nothing expected", rsp_seen);
        end else begin
          want = expected_rsp.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"result %0d: sampled %0h/%0h added %0h/%0h slot %0h/%0h ",
                        "allocs %0h/%0h samples %0h/%0h next %0h/%0h (expected/actual)"},
                       rsp_seen, want.sampled, got.sampled, want.added, got.added,
                       want.slot, got.slot, want.alloc_total, got.alloc_total,
                       want.sample_total, got.sample_total,
                       want.bytes_to_next, got.bytes_to_next);
          end
        end
        rsp_seen++;
      end
      rsp_if.ready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, so that the block fills up and stalls its input.
  initial begin : holdoff
    hold_rx = 1'b0;
    wait (hold_arm);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin : watchdog
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ENABLE)
      smp_enable = val[0];
    else if (idx == CFG_STRIDE && val >= STRIDE_MIN)
      smp_stride = val;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ev.size() != 0 || req_if.valid || expected_rsp.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic send_one(input logic [SIZE_W-1:0] size, input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    pending_ev.push_back('{size, addr});
    wait_idle();
  endtask

  task automatic run_phase(input int n_items, input int s_idle, input int r_stall);
    logic [STRIDE_W-1:0] cd;
    @(negedge clk);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 49 && smp_enable) begin
        // Now and then land exactly on the threshold, or one byte short of it.
        wait_idle();
        cd = next_countdown();
        pending_ev.push_back('{SIZE_W'(cd) - SIZE_W'($urandom_range(1)), random_addr()});
      end else begin
        pending_ev.push_back('{random_size(smp_stride), random_addr()});
      end
    end
    wait_idle();
  endtask

  initial begin : stimulus
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.alloc_size = '0;
    req_if.alloc_address = '0;
    rsp_if.ready = 1'b0;
    smp_enable = 1'b0;
    smp_stride = STRIDE_RESET;
    smp_countdown = '0;
    smp_allocs = '0;
    smp_samples = '0;
    smp_head = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fail_count = 0;
    rsp_seen = 0;
    hold_arm = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed items. Disabled straight after reset: nothing moves.
    send_one('1, '1);
    write_reg(CFG_STRIDE, 32'd1023);
    write_reg(CFG_ENABLE, 1'b1);
    send_one('0, '0);
    send_one(SIZE_W'(next_countdown()) - 1'b1, random48());
    send_one(SIZE_W'(next_countdown()), random48());
    send_one(SIZE_W'(next_countdown()), '1);
    send_one('1, '1);
    write_reg(CFG_STRIDE, STRIDE_MIN);
    send_one('1, '0);
    send_one(SIZE_W'(next_countdown()) + SIZE_W'(5 * STRIDE_MIN), random48());
    write_reg(CFG_STRIDE, 32'hFFFF_FFFF);
    send_one('0, random48());
    send_one('1, random48());
    send_one(SIZE_W'(next_countdown()) + 48'hFFFF_FFFF, random48());
    write_reg(CFG_STRIDE, 32'd0);
    send_one(SIZE_W'(next_countdown()), random48());
    write_reg(CFG_ENABLE, 1'b0);
    send_one('1, random48());
    write_reg(CFG_ENABLE, 1'b1);
    send_one(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);

    // Random phases under several settings.
    write_reg(CFG_STRIDE, STRIDE_MIN);
    run_phase(250, 0, 0);
    write_reg(CFG_STRIDE, 32'hFFFF_FFFF);
    run_phase(250, 63, 0);
    write_reg(CFG_STRIDE, $urandom_range(32'd1024, 32'hFFFF_FFFF));
    run_phase(250, 0, 63);
    write_reg(CFG_STRIDE, STRIDE_RESET);
    run_phase(250, 37, 37);

    write_reg(CFG_ENABLE, 1'b0);
    run_phase(40, 0, 0);
    write_reg(CFG_ENABLE, 1'b1);

    @(negedge clk);
    hold_arm = 1'b1;
    run_phase(50, 0, 0);

    write_reg(CFG_STRIDE, $urandom_range(1024, 8192));
    write_reg(CFG_STRIDE, $urandom_range(0, 1023));
    run_phase(250, 37, 37);
    write_reg(CFG_STRIDE, $urandom_range(32'd1024, 32'hFFFF_FFFF));
    run_phase(350, 0, 0);

    repeat (60) @(negedge clk);
    if (fail_count == 0 && expected_rsp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
